// File: rtl/core/srm_pkg.sv
// Shared types, constants and word narrowing for the sorted run merge.
// No dependencies; every other file of the block imports this package.
package srm_pkg;

  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BYTES = 8;
  localparam int WORD_W      = 64;
  localparam int WANT_W      = 2;

  typedef enum logic [WANT_W-1:0] {
    WANT_OLD  = 2'd0,
    WANT_NEW  = 2'd1,
    WANT_NONE = 2'd2
  } want_t;

  localparam logic SIDE_OLD = 1'b0;

  typedef struct packed {
    logic              side;
    logic              is_end;
    logic [WORD_W-1:0] rec_key;
    logic [WORD_W-1:0] rec_value;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
    logic              has_record;
    want_t             want_side;
    logic              merge_done;
  } result_t;

  // Keep the first nbytes bytes (clamped to 1..8), then clear everything
  // from the first zero byte on, like a C string.
  function automatic logic [WORD_W-1:0] narrow_word(input logic [WORD_W-1:0] w,
                                                     input int nbytes);
    logic [WORD_W-1:0] res;
    logic              ended;
    logic [7:0]        b;
    int                n;
    res   = '0;
    ended = 1'b0;
    n     = (nbytes < 1) ? 1 : ((nbytes > 8) ? 8 : nbytes);
    for (int i = 0; i < 8; i++) begin
      b = w[WORD_W-1-8*i -: 8];
      if (i < n) begin
        if (b == 8'h00) ended = 1'b1;
        if (!ended) res[WORD_W-1-8*i -: 8] = b;
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/srm_in_stage.sv
// Input register stage: captures one transaction and holds it until the
// merge core consumes it. Depends on srm_pkg.
module srm_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srm_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output srm_pkg::item_t item
);
  import srm_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/core/srm_merge_core.sv
// Head registers for both runs plus the one-step intake and merge decision.
// Depends on srm_pkg.
module srm_merge_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [srm_pkg::WORD_W-1:0] tombstone,
  input  logic                       fire,
  input  srm_pkg::item_t             item,
  output srm_pkg::result_t           res
);
  import srm_pkg::*;

  logic [WORD_W-1:0] old_key_r, old_val_r, new_key_r, new_val_r;
  logic              old_vld_r, old_end_r, new_vld_r, new_end_r;

  logic [WORD_W-1:0] old_key_nxt, old_val_nxt, new_key_nxt, new_val_nxt;
  logic              old_vld_nxt, old_end_nxt, new_vld_nxt, new_end_nxt;

  logic [WORD_W-1:0] k, v, tomb;

  always_comb begin
    k    = narrow_word(item.rec_key, KEY_BYTES);
    v    = narrow_word(item.rec_value, VALUE_BYTES);
    tomb = narrow_word(tombstone, VALUE_BYTES);

    old_key_nxt = old_key_r;
    old_val_nxt = old_val_r;
    old_vld_nxt = old_vld_r;
    old_end_nxt = old_end_r;
    new_key_nxt = new_key_r;
    new_val_nxt = new_val_r;
    new_vld_nxt = new_vld_r;
    new_end_nxt = new_end_r;
    res         = '0;

    // intake; records into a full head or an ended run are dropped
    if (item.side == SIDE_OLD) begin
      if (item.is_end) begin
        old_end_nxt = 1'b1;
      end else if (!old_vld_r && !old_end_r) begin
        old_key_nxt = k;
        old_val_nxt = v;
        old_vld_nxt = 1'b1;
      end
    end else begin
      if (item.is_end) begin
        new_end_nxt = 1'b1;
      end else if (!new_vld_r && !new_end_r) begin
        new_key_nxt = k;
        new_val_nxt = v;
        new_vld_nxt = 1'b1;
      end
    end

    // merge decision
    if (old_vld_nxt && new_vld_nxt) begin
      if (old_key_nxt < new_key_nxt) begin
        res.key        = old_key_nxt;
        res.value      = old_val_nxt;
        res.has_record = 1'b1;
        old_vld_nxt    = 1'b0;
      end else begin
        if (new_val_nxt != tomb) begin
          res.key        = new_key_nxt;
          res.value      = new_val_nxt;
          res.has_record = 1'b1;
        end
        if (old_key_nxt == new_key_nxt) old_vld_nxt = 1'b0;
        new_vld_nxt = 1'b0;
      end
    end else if (old_vld_nxt && new_end_nxt) begin
      res.key        = old_key_nxt;
      res.value      = old_val_nxt;
      res.has_record = 1'b1;
      old_vld_nxt    = 1'b0;
    end else if (new_vld_nxt && old_end_nxt) begin
      res.key        = new_key_nxt;
      res.value      = new_val_nxt;
      res.has_record = 1'b1;
      new_vld_nxt    = 1'b0;
    end

    if (!old_vld_nxt && !old_end_nxt) begin
      res.want_side = WANT_OLD;
    end else if (!new_vld_nxt && !new_end_nxt) begin
      res.want_side = WANT_NEW;
    end else begin
      res.want_side = WANT_NONE;
    end
    res.merge_done = old_end_nxt && new_end_nxt && !old_vld_nxt && !new_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_vld_r <= 1'b0;
      old_end_r <= 1'b0;
      new_vld_r <= 1'b0;
      new_end_r <= 1'b0;
    end else if (fire) begin
      old_vld_r <= old_vld_nxt;
      old_end_r <= old_end_nxt;
      new_vld_r <= new_vld_nxt;
      new_end_r <= new_end_nxt;
    end
  end

  // head payload: no reset, only read while the matching valid bit is set
  always_ff @(posedge clk) begin
    if (fire) begin
      old_key_r <= old_key_nxt;
      old_val_r <= old_val_nxt;
      new_key_r <= new_key_nxt;
      new_val_r <= new_val_nxt;
    end
  end

endmodule

// File: rtl/core/srm_out_stage.sv
// Result register: holds one merged result transaction until taken.
// Depends on srm_pkg.
module srm_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  srm_pkg::result_t res,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output srm_pkg::result_t out_res
);
  import srm_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res;
    end
  end

endmodule

// File: rtl/core/sorted_run_merge_with_tombstones.sv
// Two-way merge of key-sorted runs with tombstone removal. Items (records or
// end marks of the older or newer run) enter through an input register; the
// merge core then updates the two head records and makes one merge decision
// per item combinationally, and the result lands in an output register.
// Every accepted input transaction yields exactly one result transaction,
// which may or may not carry a record and always tells which run to feed next
// (older first when both are empty). Throughput is one item per clock while
// the result channel is not stalled; the result of an item is registered in
// the output stage as the item leaves the input register. Keys and values are
// narrowed to their first KEY_BYTES / VALUE_BYTES bytes and cut at the first
// zero byte. Write cfg_tombstone_value only while the block is idle.
// Depends on srm_pkg, srm_in_stage, srm_merge_core, srm_out_stage.
module sorted_run_merge_with_tombstones (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_side,
  input  logic                       in_is_end,
  input  logic [srm_pkg::WORD_W-1:0] in_rec_key,
  input  logic [srm_pkg::WORD_W-1:0] in_rec_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [srm_pkg::WORD_W-1:0] out_key,
  output logic [srm_pkg::WORD_W-1:0] out_value,
  output logic                       out_has_record,
  output logic [srm_pkg::WANT_W-1:0] out_want_side,
  output logic                       out_merge_done,
  // configuration
  input  logic                       cfg_we,
  input  logic [srm_pkg::WORD_W-1:0] cfg_tombstone_value
);
  import srm_pkg::*;

  logic [WORD_W-1:0] tombstone_r;
  item_t             in_item, item;
  logic              item_valid;
  logic              can_load;
  logic              fire;
  result_t           res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tombstone_r <= '0;
    end else if (cfg_we) begin
      tombstone_r <= cfg_tombstone_value;
    end
  end

  assign in_item.side      = in_side;
  assign in_item.is_end    = in_is_end;
  assign in_item.rec_key   = in_rec_key;
  assign in_item.rec_value = in_rec_value;

  // an item moves into the core when the result register has room
  assign fire = item_valid && can_load;

  srm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  srm_merge_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .tombstone (tombstone_r),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  srm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_key        = out_res.key;
  assign out_value      = out_res.value;
  assign out_has_record = out_res.has_record;
  assign out_want_side  = out_res.want_side;
  assign out_merge_done = out_res.merge_done;

endmodule

// File: rtl/core/srm_checker.sv
// Port-level checks for the sorted run merge, bound to the top level.
// Depends on srm_pkg and sorted_run_merge_with_tombstones.
module srm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [srm_pkg::WORD_W-1:0] out_key,
  input logic [srm_pkg::WORD_W-1:0] out_value,
  input logic                       out_has_record,
  input logic [srm_pkg::WANT_W-1:0] out_want_side,
  input logic                       out_merge_done
);
  import srm_pkg::*;

  // no result may appear right after reset, and the input is open
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("result valid or input blocked right after reset");

  // an empty result carries zero words
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_record |-> out_key == '0 && out_value == '0)
    else $error("empty result carries nonzero payload");

  // a finished merge asks for nothing more
  a_done_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_merge_done |-> out_want_side == WANT_NONE)
    else $error("merge done but a run is still requested");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_value)
      && $stable(out_has_record) && $stable(out_want_side) && $stable(out_merge_done))
    else $error("stalled result changed");

endmodule

bind sorted_run_merge_with_tombstones srm_checker u_srm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_key        (out_key),
  .out_value      (out_value),
  .out_has_record (out_has_record),
  .out_want_side  (out_want_side),
  .out_merge_done (out_merge_done)
);
